/* rtl/mlr_pkg.sv */
// Shared types and constants for the matrix layer rotator.
// Holds the input/result payload structs, register indexes and opcodes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mlr_pkg;

  // Fixed field widths
  localparam int OP_W       = 1;
  localparam int COORD_W    = 6;
  localparam int DATA_W     = 16;
  localparam int SIZE_CFG_W = 7;
  localparam int STEPS_W    = 32;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_ROW_COUNT    = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_COL_COUNT    = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_ROTATE_STEPS = 2'd2;

  localparam logic [SIZE_CFG_W-1:0] SIZE_MIN       = 7'd2;
  localparam logic [SIZE_CFG_W-1:0] SIZE_RESET     = 7'd2;
  localparam logic [STEPS_W-1:0]    ROTATE_RESET   = 32'd1;

  // Opcodes
  localparam logic [OP_W-1:0] OP_WRITE = 1'b0;
  localparam logic [OP_W-1:0] OP_READ  = 1'b1;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] row_index;
    logic [COORD_W-1:0] col_index;
    logic [DATA_W-1:0]  elem_value;
  } in_item_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_value;
    logic              range_error;
  } out_item_t;

endpackage

`default_nettype wire

/* rtl/matrix_layer_rotator.sv */
// Matrix layer rotator: a write goes straight into the store; a read passes from transfer
// to result through ring, geometry, 32 bit-serial divider steps, sum, map, RAM read, output;
// a centre-strip read skips geometry to map, and an out-of-range read goes straight to output.
// One item at a time: the next transfer is taken the cycle after the result is loaded,
// and a result stalled in the output register holds the sequencer.
// Reset (synchronous, active low) sets rows 2, cols 2, rotation 1; store not cleared.
`timescale 1ns / 1ps
`default_nettype none

module matrix_layer_rotator #(
  parameter int MAX_ROWS    = 64,
  parameter int MAX_COLS    = 64,
  parameter int VALUE_WIDTH = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output      logic                           in_stall,
  input  wire mlr_pkg::in_item_t              in_data,
  output      logic                           out_valid,
  input  wire logic                           out_stall,
  output      mlr_pkg::out_item_t             out_data,
  input  wire logic                           cfg_we,
  input  wire logic [mlr_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [mlr_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH = MAX_ROWS * MAX_COLS;
  localparam int AW    = $clog2(DEPTH);
  // wide enough for sizes, coordinates and twice the largest perimeter
  localparam int XW    = $clog2(2 * (MAX_ROWS + MAX_COLS) + 128);

  localparam logic [XW-1:0] ONE_X      = XW'(1);
  localparam logic [XW-1:0] FOUR_X     = XW'(4);
  localparam logic [XW-1:0] MAX_ROWS_X = XW'(MAX_ROWS);
  localparam logic [XW-1:0] MAX_COLS_X = XW'(MAX_COLS);
  localparam logic [AW-1:0] MAX_COLS_A = AW'(MAX_COLS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_RING,
    S_GEOM,
    S_DIV,
    S_SUM,
    S_MAP,
    S_READ,
    S_PUSH
  } state_t;

  // registers
  state_t                      state_r, state_nxt;
  logic [XW-1:0]               m_r, n_r;
  logic [mlr_pkg::STEPS_W-1:0] steps_r;
  logic [XW-1:0]               row_r, row_nxt;
  logic [XW-1:0]               col_r, col_nxt;
  logic                        err_r, err_nxt;
  logic [XW-1:0]               l_r, l_nxt;
  logic [XW-1:0]               wm1_r, wm1_nxt;
  logic [XW-1:0]               hm1_r, hm1_nxt;
  logic [XW-1:0]               total_r, total_nxt;
  logic [XW-1:0]               p_r, p_nxt;
  logic [XW-1:0]               s_r, s_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;
  logic                        out_valid_r, out_valid_nxt;
  mlr_pkg::out_item_t          out_data_r, out_data_nxt;

  // input side
  logic          in_xfer;
  logic [XW-1:0] in_row_x, in_col_x;
  logic          in_bad;

  assign in_stall = (state_r != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign in_row_x = XW'(in_data.row_index);
  assign in_col_x = XW'(in_data.col_index);
  assign in_bad   = (in_row_x >= m_r) || (in_col_x >= n_r);

  // matrix store
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [VALUE_WIDTH-1:0] ram_wdata;
  logic                   ram_re;
  logic [VALUE_WIDTH-1:0] ram_rdata;
  logic [31:0]            rd_ext;

  assign ram_we    = in_xfer && (in_data.op == mlr_pkg::OP_WRITE) && !in_bad;
  assign ram_waddr = AW'(AW'(in_data.row_index) * MAX_COLS_A + AW'(in_data.col_index));
  assign ram_wdata = VALUE_WIDTH'(32'(in_data.elem_value));
  assign ram_re    = (state_r == S_READ);
  assign rd_ext    = 32'(ram_rdata);

  mlr_ram #(
    .WIDTH (VALUE_WIDTH),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  // shift modulo perimeter
  logic          div_start;
  logic          div_done;
  logic [XW-1:0] div_rem;

  mlr_divider #(
    .DIVISOR_W (XW)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (steps_r),
    .divisor   (total_nxt),
    .done      (div_done),
    .remainder (div_rem)
  );

  // ring: least distance to an edge
  logic [XW-1:0] r_far, c_far, l_a, l_b, l_c, small_dim;
  logic          centre;

  always_comb begin
    r_far     = m_r - ONE_X - row_r;
    c_far     = n_r - ONE_X - col_r;
    l_a       = (row_r < col_r) ? row_r : col_r;
    l_b       = (r_far < c_far) ? r_far : c_far;
    l_c       = (l_a < l_b) ? l_a : l_b;
    small_dim = (m_r < n_r) ? m_r : n_r;
    centre    = (l_c >= (small_dim >> 1));
  end

  // ring geometry and position along the perimeter
  logic [XW-1:0] two_l, h_g, w_g, wm1_g, hm1_g, total_g, p_g, r_hi, c_hi;

  always_comb begin
    two_l   = l_r << 1;
    h_g     = m_r - two_l;
    w_g     = n_r - two_l;
    wm1_g   = w_g - ONE_X;
    hm1_g   = h_g - ONE_X;
    total_g = ((h_g + w_g) << 1) - FOUR_X;
    r_hi    = m_r - ONE_X - l_r;
    c_hi    = n_r - ONE_X - l_r;
    priority if (row_r == l_r && col_r < c_hi) begin
      p_g = col_r - l_r;
    end else if (col_r == c_hi && row_r < r_hi) begin
      p_g = wm1_g + (row_r - l_r);
    end else if (row_r == r_hi && col_r > l_r) begin
      p_g = wm1_g + hm1_g + (c_hi - col_r);
    end else begin
      p_g = (wm1_g << 1) + hm1_g + (r_hi - row_r);
    end
  end

  // source position: (p + steps mod total) mod total
  logic [XW:0]   sum_s;
  logic [XW-1:0] s_g;

  always_comb begin
    sum_s = {1'b0, p_r} + {1'b0, div_rem};
    if (sum_s >= {1'b0, total_r}) begin
      s_g = XW'(sum_s - {1'b0, total_r});
    end else begin
      s_g = sum_s[XW-1:0];
    end
  end

  // map source position back to a cell
  logic [XW-1:0] src_r, src_c, edge1, edge2;
  logic [AW-1:0] map_addr, own_addr;

  always_comb begin
    edge1 = wm1_r + hm1_r;
    edge2 = (wm1_r << 1) + hm1_r;
    priority if (s_r < wm1_r) begin
      src_r = l_r;
      src_c = l_r + s_r;
    end else if (s_r < edge1) begin
      src_r = l_r + (s_r - wm1_r);
      src_c = c_hi;
    end else if (s_r < edge2) begin
      src_r = r_hi;
      src_c = c_hi - (s_r - edge1);
    end else begin
      src_r = r_hi - (s_r - edge2);
      src_c = l_r;
    end
    map_addr = AW'(AW'(src_r) * MAX_COLS_A + AW'(src_c));
    own_addr = AW'(AW'(row_r) * MAX_COLS_A + AW'(col_r));
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    row_nxt       = row_r;
    col_nxt       = col_r;
    err_nxt       = err_r;
    l_nxt         = l_r;
    wm1_nxt       = wm1_r;
    hm1_nxt       = hm1_r;
    total_nxt     = total_r;
    p_nxt         = p_r;
    s_nxt         = s_r;
    addr_nxt      = addr_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    div_start     = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer && in_data.op == mlr_pkg::OP_READ) begin
          row_nxt   = in_row_x;
          col_nxt   = in_col_x;
          err_nxt   = in_bad;
          state_nxt = in_bad ? S_PUSH : S_RING;
        end
      end
      S_RING: begin
        l_nxt = l_c;
        if (centre) begin
          addr_nxt  = own_addr;
          state_nxt = S_READ;
        end else begin
          state_nxt = S_GEOM;
        end
      end
      S_GEOM: begin
        wm1_nxt   = wm1_g;
        hm1_nxt   = hm1_g;
        total_nxt = total_g;
        p_nxt     = p_g;
        div_start = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        s_nxt     = s_g;
        state_nxt = S_MAP;
      end
      S_MAP: begin
        addr_nxt  = map_addr;
        state_nxt = S_READ;
      end
      S_READ: begin
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        // load the output register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.range_error = err_r;
          out_data_nxt.read_value  = err_r ? '0 : rd_ext[mlr_pkg::DATA_W-1:0];
          state_nxt                = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // configuration values, clamped to the legal size range
  logic [XW-1:0] cfg_size_x;
  logic [XW-1:0] rows_clamped, cols_clamped;

  always_comb begin
    cfg_size_x = XW'(cfg_wdata[mlr_pkg::SIZE_CFG_W-1:0]);
    if (cfg_size_x < XW'(mlr_pkg::SIZE_MIN)) begin
      rows_clamped = XW'(mlr_pkg::SIZE_MIN);
      cols_clamped = XW'(mlr_pkg::SIZE_MIN);
    end else begin
      rows_clamped = (cfg_size_x > MAX_ROWS_X) ? MAX_ROWS_X : cfg_size_x;
      cols_clamped = (cfg_size_x > MAX_COLS_X) ? MAX_COLS_X : cfg_size_x;
    end
  end

  // state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      m_r         <= XW'(mlr_pkg::SIZE_RESET);
      n_r         <= XW'(mlr_pkg::SIZE_RESET);
      steps_r     <= mlr_pkg::ROTATE_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_addr)
          mlr_pkg::REG_ROW_COUNT:    m_r     <= rows_clamped;
          mlr_pkg::REG_COL_COUNT:    n_r     <= cols_clamped;
          mlr_pkg::REG_ROTATE_STEPS: steps_r <= cfg_wdata[mlr_pkg::STEPS_W-1:0];
          default: ;
        endcase
      end
    end
    row_r      <= row_nxt;
    col_r      <= col_nxt;
    err_r      <= err_nxt;
    l_r        <= l_nxt;
    wm1_r      <= wm1_nxt;
    hm1_r      <= hm1_nxt;
    total_r    <= total_nxt;
    p_r        <= p_nxt;
    s_r        <= s_nxt;
    addr_r     <= addr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

/* rtl/mlr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the matrix store. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mlr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output      logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // read data holds until the next read
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* rtl/mlr_divider.sv */
// Iterative restoring remainder unit: 32-bit dividend, one bit per cycle.
// Depends on mlr_pkg (STEPS_W).
`timescale 1ns / 1ps
`default_nettype none

module mlr_divider #(
  parameter int DIVISOR_W = 9
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [mlr_pkg::STEPS_W-1:0] dividend,
  input  wire logic [DIVISOR_W-1:0]       divisor,
  output      logic                       done,
  output      logic [DIVISOR_W-1:0]       remainder
);

  localparam int CNT_W = $clog2(mlr_pkg::STEPS_W + 1);

  logic                        busy_r;
  logic                        done_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [mlr_pkg::STEPS_W-1:0] dvd_r;
  logic [DIVISOR_W-1:0]        rem_r;
  logic [DIVISOR_W-1:0]        dsr_r;

  logic [DIVISOR_W:0] shifted;
  logic [DIVISOR_W:0] diff;
  logic               fits;

  // one restoring step: shift in next dividend bit, subtract if it fits
  always_comb begin
    shifted = {rem_r, dvd_r[mlr_pkg::STEPS_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    fits    = (shifted >= {1'b0, dsr_r});
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(mlr_pkg::STEPS_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[mlr_pkg::STEPS_W-2:0], 1'b0};
      rem_r <= fits ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

`default_nettype wire

/* dv/matrix_layer_rotator_checker.sv */
// Result checker for the matrix layer rotator: mirrors the register file and the
// element store, predicts each rotated read and compares it with the result channel.
// Depends on mlr_pkg.
`timescale 1ns / 1ps

module matrix_layer_rotator_checker
  import mlr_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  input  wire logic                  in_stall,
  input  wire in_item_t              in_data,
  input  wire logic                  out_valid,
  input  wire logic                  out_stall,
  input  wire out_item_t             out_data,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
  output logic [SIZE_CFG_W-1:0]      rows_in_use,
  output logic [SIZE_CFG_W-1:0]      cols_in_use,
  output int                         pending_reads,
  output int                         fail_count
);

  localparam int MAX_ROWS = 64;
  localparam int MAX_COLS = 64;
  localparam int IDX_W    = $clog2(MAX_ROWS * MAX_COLS);

  logic [DATA_W-1:0]  cell_store [MAX_ROWS*MAX_COLS];
  logic [STEPS_W-1:0] ring_shift;
  out_item_t          reads_due [$];
  out_item_t          oldest;

  function automatic logic [SIZE_CFG_W-1:0] clamp_size(input logic [CFG_DATA_W-1:0] raw,
                                                       input int limit);
    logic [SIZE_CFG_W-1:0] v;
    v = raw[SIZE_CFG_W-1:0];
    if (v < SIZE_MIN) return SIZE_MIN;
    if (v > limit) return SIZE_CFG_W'(limit);
    return v;
  endfunction

  // Element seen at (row, col) once every ring is turned counter-clockwise
  function automatic out_item_t rotated_element(input logic [COORD_W-1:0] row,
                                                input logic [COORD_W-1:0] col);
    out_item_t   res;
    int unsigned m, n, r, c, depth, h, w, perim, pos, src, sr, sc, short_side;
    m = 32'(rows_in_use);
    n = 32'(cols_in_use);
    r = 32'(row);
    c = 32'(col);
    res = '0;
    if (r >= m || c >= n) begin
      res.range_error = 1'b1;
      return res;
    end
    depth = r;
    if (c < depth) depth = c;
    if (m - 1 - r < depth) depth = m - 1 - r;
    if (n - 1 - c < depth) depth = n - 1 - c;
    short_side = (m < n) ? m : n;
    // centre strip of an odd-sized matrix does not move
    if (depth >= short_side / 2) begin
      res.read_value = cell_store[IDX_W'(r * MAX_COLS + c)];
      return res;
    end
    h = m - 2 * depth;
    w = n - 2 * depth;
    perim = 2 * (h + w) - 4;
    // position along the ring: top row, right column, bottom row, left column
    if (r == depth && c < n - 1 - depth)
      pos = c - depth;
    else if (c == n - 1 - depth && r < m - 1 - depth)
      pos = (w - 1) + (r - depth);
    else if (r == m - 1 - depth && c > depth)
      pos = (w - 1) + (h - 1) + (n - 1 - depth - c);
    else
      pos = 2 * (w - 1) + (h - 1) + (m - 1 - depth - r);
    src = (pos + ring_shift % perim) % perim;
    if (src < w - 1) begin
      sr = depth;
      sc = depth + src;
    end else if (src < (w - 1) + (h - 1)) begin
      sr = depth + (src - (w - 1));
      sc = n - 1 - depth;
    end else if (src < 2 * (w - 1) + (h - 1)) begin
      sr = m - 1 - depth;
      sc = n - 1 - depth - (src - (w - 1) - (h - 1));
    end else begin
      sr = m - 1 - depth - (src - 2 * (w - 1) - (h - 1));
      sc = depth;
    end
    res.read_value = cell_store[IDX_W'(sr * MAX_COLS + sc)];
    return res;
  endfunction

  // Results are checked before the same-edge input transfer is predicted
  always @(posedge clk) begin
    if (!rst_n) begin
      rows_in_use <= SIZE_RESET;
      cols_in_use <= SIZE_RESET;
      ring_shift  <= ROTATE_RESET;
      reads_due.delete();
      pending_reads = 0;
      fail_count    = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (reads_due.size() == 0) begin
          $error("result transfer with no read outstanding: read_value=%h range_error=%b",
                 out_data.read_value, out_data.range_error);
          fail_count++;
        end else begin
          oldest = reads_due.pop_front();
          if (out_data.read_value !== oldest.read_value) begin
            $error("read_value mismatch: expected %h, actual %h",
                   oldest.read_value, out_data.read_value);
            fail_count++;
          end
          if (out_data.range_error !== oldest.range_error) begin
            $error("range_error mismatch: expected %b, actual %b",
                   oldest.range_error, out_data.range_error);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (in_data.op == OP_READ)
          reads_due.push_back(rotated_element(in_data.row_index, in_data.col_index));
        else if (in_data.row_index < rows_in_use && in_data.col_index < cols_in_use)
          cell_store[IDX_W'(int'(in_data.row_index) * MAX_COLS + int'(in_data.col_index))] =
            in_data.elem_value;
      end

      if (cfg_we) begin
        case (cfg_addr)
          REG_ROW_COUNT:    rows_in_use <= clamp_size(cfg_wdata, MAX_ROWS);
          REG_COL_COUNT:    cols_in_use <= clamp_size(cfg_wdata, MAX_COLS);
          REG_ROTATE_STEPS: ring_shift  <= cfg_wdata;
          default: ;
        endcase
      end

      pending_reads = reads_due.size();
    end
  end

endmodule

/* dv/matrix_layer_rotator_tb.sv */
// Top of the matrix layer rotator testbench: clock, reset, stimulus and verdict.
// Drives element writes and rotated reads over several matrix sizes and shifts.
// Depends on mlr_pkg, matrix_layer_rotator and matrix_layer_rotator_checker.
`timescale 1ns / 1ps

module matrix_layer_rotator_tb;
  import mlr_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int DRAIN_CYCLES = 45;   // longest read latency plus margin
  localparam int QUIET_LIMIT  = 2000;
  localparam int GRID         = 64;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  logic [SIZE_CFG_W-1:0] rows_in_use;
  logic [SIZE_CFG_W-1:0] cols_in_use;
  int                    pending_reads;
  int                    fail_count;

  bit cell_written [GRID][GRID];
  bit gaps_on;
  int items_sent;
  int stall_hold;
  int quiet_cycles;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix_layer_rotator uut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  matrix_layer_rotator_checker rotation_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_addr      (cfg_addr),
    .cfg_wdata     (cfg_wdata),
    .rows_in_use   (rows_in_use),
    .cols_in_use   (cols_in_use),
    .pending_reads (pending_reads),
    .fail_count    (fail_count)
  );

  // Result side back-pressure: random stall bursts while gaps are on
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      stall_hold <= stall_hold - 1;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_hold <= $urandom_range(0, 5);
    end else begin
      out_stall <= 1'b0;
    end
  end

  function automatic int unsigned ring_depth(input int unsigned r, c, m, n);
    int unsigned d;
    d = r;
    if (c < d) d = c;
    if (m - 1 - r < d) d = m - 1 - r;
    if (n - 1 - c < d) d = n - 1 - c;
    return d;
  endfunction

  // Shift values: random, near zero, near the top, and whole turns of the outer ring (or one more)
  function automatic logic [STEPS_W-1:0] random_steps(input int unsigned m, n);
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 600);
      2: return 32'hFFFF_FFFF - $urandom_range(0, 600);
      default: return $urandom_range(1, 5) * (2 * (m + n) - 4) + $urandom_range(0, 1);
    endcase
  endfunction

  // One input transfer; valid stays high on return so the next item can follow
  task automatic send_item(input logic [OP_W-1:0] op, input logic [COORD_W-1:0] r, c,
                           input logic [DATA_W-1:0] v);
    in_item_t item;
    item.op         = op;
    item.row_index  = r;
    item.col_index  = c;
    item.elem_value = v;
    if (op == OP_READ || (r < rows_in_use && c < cols_in_use)) items_sent++;
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cell(input logic [COORD_W-1:0] r, c, input logic [DATA_W-1:0] v);
    send_item(OP_WRITE, r, c, v);
    if (r < rows_in_use && c < cols_in_use) cell_written[r][c] = 1'b1;
  endtask

  // Write every still-unwritten cell the read of (r, c) may land on
  task automatic fill_ring(input logic [COORD_W-1:0] r, c);
    int unsigned m, n, depth;
    bit          centre;
    m = 32'(rows_in_use);
    n = 32'(cols_in_use);
    depth = ring_depth(32'(r), 32'(c), m, n);
    centre = depth >= (((m < n) ? m : n) / 2);
    for (int rr = 0; rr < m; rr++)
      for (int cc = 0; cc < n; cc++)
        if (!cell_written[COORD_W'(rr)][COORD_W'(cc)] &&
            (centre ? (rr == r && cc == c) : ring_depth(rr, cc, m, n) == depth))
          write_cell(COORD_W'(rr), COORD_W'(cc), DATA_W'($urandom()));
  endtask

  task automatic read_cell(input logic [COORD_W-1:0] r, c);
    if (r < rows_in_use && c < cols_in_use) fill_ring(r, c);
    send_item(OP_READ, r, c, DATA_W'($urandom()));
  endtask

  // Lower valid, wait for every read result, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_reads != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Back-to-back register writes while the block is idle, unmapped index last
  task automatic apply_setting(input logic [CFG_DATA_W-1:0] rows_w, cols_w, steps_w);
    settle();
    cfg_we    <= 1'b1;
    cfg_addr  <= REG_ROW_COUNT;
    cfg_wdata <= rows_w;
    @(negedge clk);
    cfg_addr  <= REG_COL_COUNT;
    cfg_wdata <= cols_w;
    @(negedge clk);
    cfg_addr  <= REG_ROTATE_STEPS;
    cfg_wdata <= steps_w;
    @(negedge clk);
    cfg_addr  <= REG_UNMAPPED;
    cfg_wdata <= $urandom();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random mix of reads and writes, some of them outside the matrix in use
  task automatic run_mix(input int quota);
    int               stop_at;
    int unsigned      m, n, pick;
    logic [COORD_W-1:0] r, c;
    stop_at = items_sent + quota;
    m = 32'(rows_in_use);
    n = 32'(cols_in_use);
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      r = COORD_W'($urandom_range(0, m - 1));
      c = COORD_W'($urandom_range(0, n - 1));
      if (pick < 15 && (m < GRID || n < GRID)) begin
        if (m < GRID && (n == GRID || $urandom_range(0, 1) == 1))
          r = COORD_W'($urandom_range(m, GRID - 1));
        else
          c = COORD_W'($urandom_range(n, GRID - 1));
        if (pick < 10) read_cell(r, c);
        else write_cell(r, c, DATA_W'($urandom()));
      end else if (pick < 45) begin
        write_cell(r, c, DATA_W'($urandom()));
      end else begin
        read_cell(r, c);
      end
    end
  endtask

  // Watchdog: cycles without any transfer on either channel
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned m, n;
    gaps_on    = 1'b1;
    items_sent = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: 2x2 after reset, one step; value extremes and out-of-range accesses
    write_cell(6'd0, 6'd0, 16'h0000);
    write_cell(6'd0, 6'd1, 16'hFFFF);
    write_cell(6'd1, 6'd0, 16'hA5A5);
    write_cell(6'd1, 6'd1, 16'h5A5A);
    write_cell(6'd63, 6'd63, 16'h1234);
    write_cell(6'd2, 6'd0, 16'h4321);
    read_cell(6'd0, 6'd0);
    read_cell(6'd0, 6'd1);
    read_cell(6'd1, 6'd1);
    read_cell(6'd1, 6'd0);
    read_cell(6'd63, 6'd63);
    read_cell(6'd0, 6'd2);
    read_cell(6'd2, 6'd0);

    // Odd square with a fixed centre, no shift
    apply_setting(32'd3, 32'd3, 32'd0);
    run_mix(120);
    // Largest shift
    apply_setting(32'd5, 32'd7, 32'hFFFF_FFFF);
    run_mix(150);
    // Row count below the minimum clamps to two
    apply_setting(32'd0, 32'd9, random_steps(2, 9));
    run_mix(120);
    // Row count above the maximum clamps to 64
    apply_setting(32'd127, 32'd2, random_steps(64, 2));
    run_mix(150);
    // Upper bits of the size word are ignored; column count of one clamps
    apply_setting(32'hFFFF_FF85, 32'd1, random_steps(5, 2));
    run_mix(100);
    // Full-size matrix, no idling on either side
    gaps_on = 1'b0;
    apply_setting(32'd64, 32'd64, random_steps(64, 64));
    run_mix(400);
    gaps_on = 1'b1;

    for (int k = 0; k < 8; k++) begin
      m = $urandom_range(2, 12);
      n = $urandom_range(2, 12);
      apply_setting({25'($urandom()), 7'(m)}, 32'(n), random_steps(m, n));
      run_mix(100);
    end

    // Closing stretch without idling
    gaps_on = 1'b0;
    apply_setting(32'd7, 32'd4, random_steps(7, 4));
    run_mix(100);

    settle();
    if (fail_count == 0 && pending_reads == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
